// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/tlr_pkg.sv =====
// Types and constants of the telnet line receiver.
package tlr_pkg;

  localparam int unsigned LineCapacity = 4096;
  localparam int unsigned PosW         = 12;
  localparam int unsigned MaxResults   = 3;
  localparam int unsigned CntW         = 2;
  localparam int unsigned IdxW         = 8;

  // line ends once a store brings the length here
  localparam logic [PosW-1:0] LenFull = PosW'(LineCapacity - 1);

  typedef enum logic [1:0] {
    KindEcho  = 2'd0,
    KindStore = 2'd1,
    KindDone  = 2'd2,
    KindHelp  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      byte_value;
    logic [PosW-1:0] position;
  } res_t;

  // parse state codes
  localparam logic [2:0] PsNormal    = 3'd0;
  localparam logic [2:0] PsIac       = 3'd1;
  localparam logic [2:0] PsOption    = 3'd2;
  localparam logic [2:0] PsSubneg    = 3'd3;
  localparam logic [2:0] PsSubnegIac = 3'd4;
  localparam logic [2:0] PsCr        = 3'd5;

  // configuration register indexes
  localparam logic [IdxW-1:0] RegEchoEnable = IdxW'(0);
  localparam logic [IdxW-1:0] RegHelpEnable = IdxW'(1);

  // telnet and control bytes
  localparam logic [7:0] ChIac = 8'd255;
  localparam logic [7:0] ChWill = 8'd251;
  localparam logic [7:0] ChSb  = 8'd250;
  localparam logic [7:0] ChSe  = 8'd240;
  localparam logic [7:0] ChBs  = 8'h08;
  localparam logic [7:0] ChDel = 8'h7F;
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChQm  = 8'h3F;
  localparam logic [7:0] ChSp  = 8'h20;
  localparam logic [7:0] ChNul = 8'h00;

endpackage

// ===== rtl/telnet_line_receiver_unit.sv =====
// Telnet line receiver: strips IAC commands, edits the line, emits store/echo/done/help results.
//
//  channel   | dir | handshake                 | payload
//  s_axis    | in  | s_axis_tvalid/tready      | tdata[7:0] rx_byte
//  m_axis    | out | m_axis_tvalid/tready      | tdata byte_value,position; tuser kind; tlast
//  cfg       | in  | cfg_valid_i/cfg_ready_o   | cfg_index_i, cfg_data_i[0]
//
// A byte is decoded in the cycle it is transferred; its 0 to 3 results are loaded into
// a three-entry output shift register and leave one per cycle while m_axis is ready.
// The next byte is taken in the cycle the last pending result leaves. Reset clears
// parse state, line length and the output queue and sets both enables. A stalled
// m_axis holds the queue and blocks input.
`include "assert_macros.svh"

module telnet_line_receiver_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,   // [7:0] rx_byte
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [23:0]              m_axis_tdata,   // [7:0] byte_value, [19:8] position, 0
  output logic [1:0]               m_axis_tuser,   // [1:0] kind
  output logic                     m_axis_tlast,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [tlr_pkg::IdxW-1:0] cfg_index_i,
  input  logic [7:0]               cfg_data_i
);
  import tlr_pkg::*;

  logic            echo_en_q, help_en_q;
  logic [2:0]      state_q, state_d;
  logic [PosW-1:0] len_q, len_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  res_t            buf_q [MaxResults];
  res_t            buf_d [MaxResults];
  res_t            res   [MaxResults];
  logic [CntW-1:0] res_cnt;
  logic            in_xfer, out_xfer;
  logic            do_keep, do_end_echo, do_end_quiet, do_help, do_erase;
  logic [7:0]      rx;

  assign rx            = s_axis_tdata;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (cnt_q != '0);
  assign s_axis_tready = (cnt_q == '0) || ((cnt_q == CntW'(1)) && m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tdata  = {4'd0, buf_q[0].position, buf_q[0].byte_value};
  assign m_axis_tuser  = buf_q[0].kind;
  assign m_axis_tlast  = (cnt_q == CntW'(1));

  // decode of the current byte
  always_comb begin
    do_keep      = 1'b0;
    do_end_echo  = 1'b0;
    do_end_quiet = 1'b0;
    do_help      = 1'b0;
    do_erase     = 1'b0;
    state_d      = state_q;
    unique case (state_q)
      PsIac: begin
        state_d = PsNormal;
        if (rx == ChIac) begin
          do_keep = 1'b1;
        end else if (rx >= ChWill) begin
          state_d = PsOption;
        end else if (rx == ChSb) begin
          state_d = PsSubneg;
        end
      end
      PsOption: state_d = PsNormal;
      PsSubneg: begin
        if (rx == ChIac) state_d = PsSubnegIac;
      end
      PsSubnegIac: state_d = (rx == ChSe) ? PsNormal : PsSubneg;
      PsCr: begin
        state_d     = PsNormal;
        do_end_echo = 1'b1;
      end
      default: begin
        state_d = PsNormal;
        priority if (rx == ChIac) begin
          state_d = PsIac;
        end else if (rx == ChCr) begin
          state_d = PsCr;
        end else if (rx == ChLf) begin
          do_end_echo = 1'b1;
        end else if (rx == ChQm) begin
          do_help      = help_en_q;
          do_end_quiet = !help_en_q;
        end else if (rx == ChBs || rx == ChDel) begin
          do_erase = 1'b1;
        end else if (rx != ChNul) begin
          do_keep = 1'b1;
        end
      end
    endcase
  end

  // result list and next length
  always_comb begin
    for (int i = 0; i < MaxResults; i++) res[i] = '{KindEcho, 8'd0, '0};
    res_cnt = '0;
    len_d   = len_q;
    if (do_keep) begin
      res[res_cnt] = '{KindStore, rx, len_q};
      res_cnt      = res_cnt + CntW'(1);
      len_d        = len_q + PosW'(1);
      if (echo_en_q) begin
        res[res_cnt] = '{KindEcho, rx, '0};
        res_cnt      = res_cnt + CntW'(1);
      end
      if (len_d == LenFull) begin
        res[res_cnt] = '{KindDone, 8'd0, len_d};
        res_cnt      = res_cnt + CntW'(1);
        len_d        = '0;
      end
    end
    if (do_end_echo || do_end_quiet) begin
      if (do_end_echo && echo_en_q) begin
        res[0]  = '{KindEcho, ChCr, '0};
        res[1]  = '{KindEcho, ChLf, '0};
        res_cnt = CntW'(2);
      end
      res[res_cnt] = '{KindDone, 8'd0, len_q};
      res_cnt      = res_cnt + CntW'(1);
      len_d        = '0;
    end
    if (do_help) begin
      res[0]  = '{KindHelp, 8'd0, len_q};
      res_cnt = CntW'(1);
    end
    if (do_erase && (len_q != '0)) begin
      len_d = len_q - PosW'(1);
      if (echo_en_q) begin
        res[0]  = '{KindEcho, ChBs, '0};
        res[1]  = '{KindEcho, ChSp, '0};
        res[2]  = '{KindEcho, ChBs, '0};
        res_cnt = CntW'(3);
      end
    end
  end

  // output queue: load on input transfer, else shift on output transfer
  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < MaxResults; i++) buf_d[i] = buf_q[i];
    if (in_xfer) begin
      cnt_d = res_cnt;
      for (int i = 0; i < MaxResults; i++) buf_d[i] = res[i];
    end else if (out_xfer) begin
      cnt_d = cnt_q - CntW'(1);
      for (int i = 0; i < MaxResults - 1; i++) buf_d[i] = buf_q[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= PsNormal;
      len_q     <= '0;
      cnt_q     <= '0;
      echo_en_q <= 1'b1;
      help_en_q <= 1'b1;
    end else begin
      cnt_q <= cnt_d;
      if (in_xfer) begin
        state_q <= state_d;
        len_q   <= len_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegEchoEnable) echo_en_q <= cfg_data_i[0];
        if (cfg_index_i == RegHelpEnable) help_en_q <= cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxResults; i++) buf_q[i] <= buf_d[i];
  end

  `ASSERT_IMPLIES(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(MaxResults))
  `ASSERT_IMPLIES(a_len_below_full, clk_i, rst_ni, 1'b1, len_q != LenFull)
  `ASSERT_IMPLIES(a_no_take_while_busy, clk_i, rst_ni, cnt_q > CntW'(1), !s_axis_tready)
  `ASSERT_NEXT(a_drain_step, clk_i, rst_ni, out_xfer && (cnt_q > CntW'(1)), cnt_q == $past(cnt_q) - CntW'(1))

endmodule
